// ===== rtl/core/svpd_pkg.sv =====
`default_nettype none
package svpd_pkg;

  localparam int FracBits  = 15;
  localparam int RootSteps = 16;
  localparam int DivSteps  = 16;
  localparam int FrontLen  = RootSteps + 2;
  localparam int QueueLen  = 4;
  localparam int One       = 1 << FracBits;

  localparam logic [31:0] InvSqrt3  = 32'd2479700525;
  localparam logic [31:0] Sqrt3Half = 32'd3719550786;
  // 4*m2 > 3 in Q(2*FracBits) is the same as m2 > 3 * 2^(2*FracBits-2).
  localparam logic [31:0] LimitThresh = 32'd3 << (2 * FracBits - 2);
  localparam logic [16:0] DutyTop = 17'(1 << (FracBits + 1));

  typedef enum logic [2:0] {
    SEC_S1 = 3'd0,
    SEC_S2 = 3'd1,
    SEC_S3 = 3'd2,
    SEC_S4 = 3'd3,
    SEC_S5 = 3'd4,
    SEC_S6 = 3'd5
  } sector_e;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [16:0]        mag;
    logic               lim;
  } vec_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    sector_e     sector;
    logic        lim;
  } duty_t;

  function automatic logic [15:0] to_q16(input logic signed [21:0] d2);
    logic [16:0] u;
    logic [32:0] r;
    if (d2 < 0) begin
      u = '0;
    end else if (d2 > $signed({5'b0, DutyTop})) begin
      u = DutyTop;
    end else begin
      u = d2[16:0];
    end
    r = ({u, 16'b0} + (33'd1 << FracBits)) >> (FracBits + 1);
    return (r > 33'd65535) ? 16'hFFFF : r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/space_vector_pwm_duty.sv =====
// Space vector PWM duty generator, six sectors, centered zero vectors.
// Slave stream: one beat carries one alpha/beta voltage vector (signed Q1.15).
// Master stream: one beat per input beat with the three phase duties (Q0.16),
// the sector index and a flag telling that the vector was pulled back onto
// the sqrt(3)/2 circle. Results leave in input order.
// Throughput is one vector per cycle while tready is high. The front holds
// the squaring stage, the limit test and a 16-stage square root, one root bit
// per stage. The back holds a 16-stage restoring divider (one quotient bit per
// stage, alpha and beta in two lanes), the beta/sqrt3 multiply and the duty
// stage, which is also the output register.
// A 4-entry queue sits between front and back, so the front keeps taking beats
// while the receiver stalls, until the queue is full and the last front stage
// holds a beat; then tready drops. Every stage holds its data during a stall.
// Reset empties all pipelines and the queue; the block holds no other state.
`default_nettype none
module space_vector_pwm_duty (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // alpha_volt [15:0], beta_volt [31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // duty_a [15:0], duty_b [31:16], duty_c [47:32], sector_index [50:48],
  // amplitude_limited [51], zero [55:52]
  output logic [55:0]      m_axis_tdata
);
  import svpd_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  vec_t  f_data, q_data;
  duty_t res;

  svpd_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .alpha_i     (s_axis_tdata[15:0]),
    .beta_i      (s_axis_tdata[31:16]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_o       (f_data)
  );

  svpd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  svpd_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_i        (q_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {4'b0, res.lim, res.sector, res.duty_c, res.duty_b, res.duty_a};

endmodule
`default_nettype wire

// ===== rtl/core/svpd_mag.sv =====
`default_nettype none
module svpd_mag (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] alpha_i,
  input  wire logic signed [15:0] beta_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output svpd_pkg::vec_t          out_o
);
  import svpd_pkg::*;

  logic               vld_q [FrontLen];
  logic               vld_d [FrontLen];
  logic signed [15:0] al_q  [FrontLen];
  logic signed [15:0] al_d  [FrontLen];
  logic signed [15:0] be_q  [FrontLen];
  logic signed [15:0] be_d  [FrontLen];
  logic               lim_q [FrontLen];
  logic               lim_d [FrontLen];
  logic [31:0]        rem_q [FrontLen];
  logic [31:0]        rem_d [FrontLen];
  logic [31:0]        root_q[FrontLen];
  logic [31:0]        root_d[FrontLen];
  logic               en;
  logic signed [31:0] sq_a, sq_b;
  logic [31:0]        trial, bitv, m2;
  logic [16:0]        mag;

  assign en          = !vld_q[FrontLen-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[FrontLen-1];

  always_comb begin
    sq_a = alpha_i * alpha_i;
    sq_b = beta_i * beta_i;
    // The first stage keeps the two squares in the remainder and root slots.
    vld_d[0]  = in_valid_i;
    al_d[0]   = alpha_i;
    be_d[0]   = beta_i;
    lim_d[0]  = 1'b0;
    rem_d[0]  = sq_a;
    root_d[0] = sq_b;
    m2        = rem_q[0] + root_q[0];
    vld_d[1]  = vld_q[0];
    al_d[1]   = al_q[0];
    be_d[1]   = be_q[0];
    lim_d[1]  = m2 > LimitThresh;
    rem_d[1]  = m2;
    root_d[1] = '0;
    trial     = '0;
    bitv      = '0;
    for (int k = 2; k < FrontLen; k++) begin
      bitv     = 32'd1 << (30 - 2 * (k - 2));
      trial    = root_q[k-1] + bitv;
      vld_d[k] = vld_q[k-1];
      al_d[k]  = al_q[k-1];
      be_d[k]  = be_q[k-1];
      lim_d[k] = lim_q[k-1];
      if (rem_q[k-1] >= trial) begin
        rem_d[k]  = rem_q[k-1] - trial;
        root_d[k] = (root_q[k-1] >> 1) + bitv;
      end else begin
        rem_d[k]  = rem_q[k-1];
        root_d[k] = root_q[k-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FrontLen; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < FrontLen; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < FrontLen; k++) begin
        al_q[k]   <= al_d[k];
        be_q[k]   <= be_d[k];
        lim_q[k]  <= lim_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  // Round the floor root to nearest; the remainder decides.
  always_comb begin
    mag = root_q[FrontLen-1][16:0] +
          17'(rem_q[FrontLen-1] > root_q[FrontLen-1]);
    if (mag == '0) begin
      mag = 17'd1;
    end
    out_o.alpha = al_q[FrontLen-1];
    out_o.beta  = be_q[FrontLen-1];
    out_o.mag   = mag;
    out_o.lim   = lim_q[FrontLen-1];
  end

endmodule
`default_nettype wire

// ===== rtl/core/svpd_fifo.sv =====
`default_nettype none
module svpd_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  svpd_pkg::vec_t push_data_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output svpd_pkg::vec_t pop_data_o
);
  import svpd_pkg::*;

  localparam int PtrW = $clog2(QueueLen);

  vec_t            mem_q [QueueLen];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != (PtrW + 1)'(QueueLen);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/svpd_duty.sv =====
`default_nettype none
module svpd_duty (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  svpd_pkg::vec_t  in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output svpd_pkg::duty_t out_o
);
  import svpd_pkg::*;

  localparam int DivLen = DivSteps + 1;

  // Divider lanes: index 0 holds the rounded numerators, index k has k quotient bits.
  logic               dv_vld_q [DivLen];
  logic               dv_vld_d [DivLen];
  logic [48:0]        rem_a_q  [DivLen];
  logic [48:0]        rem_a_d  [DivLen];
  logic [48:0]        rem_b_q  [DivLen];
  logic [48:0]        rem_b_d  [DivLen];
  logic [15:0]        q_a_q    [DivLen];
  logic [15:0]        q_a_d    [DivLen];
  logic [15:0]        q_b_q    [DivLen];
  logic [15:0]        q_b_d    [DivLen];
  logic [48:0]        den_q    [DivLen];
  logic [48:0]        den_d    [DivLen];
  logic signed [15:0] al_q     [DivLen];
  logic signed [15:0] al_d     [DivLen];
  logic signed [15:0] be_q     [DivLen];
  logic signed [15:0] be_d     [DivLen];
  logic               lim_q    [DivLen];
  logic               lim_d    [DivLen];

  logic               tv_vld_q;
  logic signed [17:0] tv_al_q, tv_al_d, tv_t_q, tv_t_d;
  logic               tv_lim_q;
  logic               out_vld_q;
  duty_t              out_q, out_d;
  logic               en;

  logic signed [16:0] ex_a, ex_b;
  logic [16:0]        abs_a, abs_b;
  logic [48:0]        den0, dsh;
  logic signed [17:0] bev;
  logic [16:0]        bm;
  logic [48:0]        tprod;

  logic signed [19:0] a, b, c;
  logic signed [21:0] x, y, z, da, db, dc, one;
  sector_e            sec;

  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    ex_a  = 17'(in_i.alpha);
    ex_b  = 17'(in_i.beta);
    abs_a = (ex_a < 0) ? 17'(-ex_a) : 17'(ex_a);
    abs_b = (ex_b < 0) ? 17'(-ex_b) : 17'(ex_b);
    den0  = 49'(in_i.mag) << (32 - FracBits);
    dv_vld_d[0] = in_valid_i;
    rem_a_d[0]  = 49'(abs_a) * 49'(Sqrt3Half) + (den0 >> 1);
    rem_b_d[0]  = 49'(abs_b) * 49'(Sqrt3Half) + (den0 >> 1);
    q_a_d[0]    = '0;
    q_b_d[0]    = '0;
    den_d[0]    = den0;
    al_d[0]     = in_i.alpha;
    be_d[0]     = in_i.beta;
    lim_d[0]    = in_i.lim;
    dsh         = '0;
    // One restoring step per stage, most significant quotient bit first.
    for (int k = 1; k < DivLen; k++) begin
      dsh         = den_q[k-1] << (DivSteps - k);
      dv_vld_d[k] = dv_vld_q[k-1];
      den_d[k]    = den_q[k-1];
      al_d[k]     = al_q[k-1];
      be_d[k]     = be_q[k-1];
      lim_d[k]    = lim_q[k-1];
      rem_a_d[k]  = rem_a_q[k-1];
      rem_b_d[k]  = rem_b_q[k-1];
      q_a_d[k]    = q_a_q[k-1];
      q_b_d[k]    = q_b_q[k-1];
      if (rem_a_q[k-1] >= dsh) begin
        rem_a_d[k]              = rem_a_q[k-1] - dsh;
        q_a_d[k][DivSteps - k]  = 1'b1;
      end
      if (rem_b_q[k-1] >= dsh) begin
        rem_b_d[k]              = rem_b_q[k-1] - dsh;
        q_b_d[k][DivSteps - k]  = 1'b1;
      end
    end
  end

  // Pick the scaled or the original vector, then beta/sqrt3 on the magnitude.
  always_comb begin
    if (lim_q[DivLen-1]) begin
      tv_al_d = al_q[DivLen-1][15] ? -18'(q_a_q[DivLen-1]) : 18'(q_a_q[DivLen-1]);
      bev     = be_q[DivLen-1][15] ? -18'(q_b_q[DivLen-1]) : 18'(q_b_q[DivLen-1]);
    end else begin
      tv_al_d = 18'(al_q[DivLen-1]);
      bev     = 18'(be_q[DivLen-1]);
    end
    bm     = (bev < 0) ? 17'(-bev) : 17'(bev);
    tprod  = 49'(bm) * 49'(InvSqrt3) + (49'd1 << 31);
    tv_t_d = (bev < 0) ? -18'(tprod[48:32]) : 18'(tprod[48:32]);
  end

  always_comb begin
    one = 22'(One);
    a   = 20'(tv_al_q) - 20'(tv_t_q);
    b   = 20'(tv_t_q) <<< 1;
    c   = -(a + b);
    // Zero counts as non-negative, except for b when c is non-negative.
    if (c < 0) begin
      if (a < 0) begin
        sec = SEC_S2;
      end else if (b < 0) begin
        sec = SEC_S6;
      end else begin
        sec = SEC_S1;
      end
    end else begin
      if (a < 0) begin
        sec = (b <= 0) ? SEC_S4 : SEC_S3;
      end else begin
        sec = SEC_S5;
      end
    end
    case (sec)
      SEC_S1: begin
        x = 22'(a); y = 22'(b);
      end
      SEC_S2: begin
        x = -22'(c); y = -22'(a);
      end
      SEC_S3: begin
        x = 22'(b); y = 22'(c);
      end
      SEC_S4: begin
        x = -22'(a); y = -22'(b);
      end
      SEC_S5: begin
        x = 22'(c); y = 22'(a);
      end
      default: begin
        x = -22'(b); y = -22'(c);
      end
    endcase
    z = one - (x + y);
    case (sec)
      SEC_S1: begin
        da = 22'sd2 * (x + y) + z; db = 22'sd2 * y + z; dc = z;
      end
      SEC_S2: begin
        da = 22'sd2 * x + z; db = 22'sd2 * (x + y) + z; dc = z;
      end
      SEC_S3: begin
        da = z; db = 22'sd2 * (x + y) + z; dc = 22'sd2 * y + z;
      end
      SEC_S4: begin
        da = z; db = 22'sd2 * x + z; dc = 22'sd2 * (x + y) + z;
      end
      SEC_S5: begin
        da = 22'sd2 * y + z; db = z; dc = 22'sd2 * (x + y) + z;
      end
      default: begin
        da = 22'sd2 * (x + y) + z; db = z; dc = 22'sd2 * x + z;
      end
    endcase
    out_d.duty_a = to_q16(da);
    out_d.duty_b = to_q16(db);
    out_d.duty_c = to_q16(dc);
    out_d.sector = sec;
    out_d.lim    = tv_lim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLen; k++) dv_vld_q[k] <= 1'b0;
      tv_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DivLen; k++) dv_vld_q[k] <= dv_vld_d[k];
      tv_vld_q  <= dv_vld_q[DivLen-1];
      out_vld_q <= tv_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < DivLen; k++) begin
        rem_a_q[k] <= rem_a_d[k];
        rem_b_q[k] <= rem_b_d[k];
        q_a_q[k]   <= q_a_d[k];
        q_b_q[k]   <= q_b_d[k];
        den_q[k]   <= den_d[k];
        al_q[k]    <= al_d[k];
        be_q[k]    <= be_d[k];
        lim_q[k]   <= lim_d[k];
      end
      tv_al_q  <= tv_al_d;
      tv_t_q   <= tv_t_d;
      tv_lim_q <= lim_q[DivLen-1];
      out_q    <= out_d;
    end
  end

endmodule
`default_nettype wire
